FILE: sv/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned KEY_W    = 32;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_WR,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_OUT
  } state_e;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
  } mhpq_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic signed [KEY_W-1:0] top_key;
    logic [CNT_W-1:0]        count;
    logic                    is_empty;
    status_e                 status;
  } mhpq_out_t;

  function automatic logic [ADDR_W-1:0] parent_idx(input logic [ADDR_W-1:0] p);
    return (p - ADDR_W'(1)) >> 1;
  endfunction

endpackage

`default_nettype wire

FILE: sv/max_heap_priority_queue_top.sv
// Priority queue of signed 32-bit keys held as a binary max-heap in one
// 1024-entry single-write-port memory.
// Input channel: in_valid_i / in_stall_o with in_req_i (op, key). An op of
// insert adds the key; an op of remove takes out the current maximum.
// Output channel: out_valid_o / out_stall_i with out_rsp_o, one response per
// request: removed key, maximum afterwards, element count, empty flag, status.
// The next request can be taken in the cycle that the response to the
// previous one is first offered. Each heap level walked takes a parent read
// and compare on insert, and a left and a right child read on remove, since
// the memory has a single registered read port; a full 1024-entry heap has
// 11 levels.
// The block takes one request at a time and holds in_stall_o high while it
// works. A finished response sits in an output register, so a new request is
// taken while the receiver stalls; the next response then waits until the
// previous one is taken.
// Reset empties the queue at once; memory contents need no clearing since only
// entries below the element count are ever read.
// An insert into a full queue is dropped with status full; a remove from an
// empty queue returns the most negative key with status empty.
`default_nettype none

module max_heap_priority_queue_top
  import mhpq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire mhpq_in_t  in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output mhpq_out_t      out_rsp_o
);

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rdata_q;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [ADDR_W-1:0]       pos_q, pos_d;
  logic signed [KEY_W-1:0] cur_q, cur_d;
  logic signed [KEY_W-1:0] best_key_q, best_key_d;
  logic [ADDR_W-1:0]       best_idx_q, best_idx_d;
  logic signed [KEY_W-1:0] top_q, top_d;
  logic signed [KEY_W-1:0] removed_q, removed_d;
  status_e                 status_q, status_d;
  mhpq_out_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic [ADDR_W-1:0]       raddr;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic signed [KEY_W-1:0] wdata;

  logic [CNT_W:0]          cnt_ext;
  logic [CNT_W:0]          left_w;
  logic [CNT_W:0]          right_w;
  logic [CNT_W:0]          next_left_w;
  logic [CNT_W-1:0]        last_idx;
  logic [ADDR_W-1:0]       up_parent;
  logic                    go_resolve;
  logic signed [KEY_W-1:0] cand_key;
  logic [ADDR_W-1:0]       cand_idx;

  assign cnt_ext     = {1'b0, cnt_q};
  assign left_w      = {1'b0, pos_q, 1'b1};
  assign right_w     = left_w + (CNT_W+1)'(1);
  assign next_left_w = {1'b0, cand_idx, 1'b1};
  assign last_idx    = cnt_q - CNT_W'(1);
  assign up_parent   = parent_idx(pos_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cur_q      <= cur_d;
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
    top_q      <= top_d;
    removed_q  <= removed_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    best_key_d  = best_key_q;
    best_idx_d  = best_idx_q;
    removed_d   = removed_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    raddr       = '0;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = cur_q;
    go_resolve  = 1'b0;
    cand_key    = cur_q;
    cand_idx    = pos_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          removed_d = KEY_MIN;
          status_d  = ST_OK;
          if (in_req_i.op == OP_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_OUT;
            end else begin
              pos_d = cnt_q[ADDR_W-1:0];
              cur_d = in_req_i.key;
              cnt_d = cnt_q + CNT_W'(1);
              if (cnt_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = in_req_i.key;
                state_d = S_OUT;
              end else begin
                raddr   = parent_idx(cnt_q[ADDR_W-1:0]);
                state_d = S_UP;
              end
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_OUT;
            end else begin
              removed_d = top_q;
              cnt_d     = last_idx;
              pos_d     = '0;
              if (cnt_q == CNT_W'(1)) begin
                state_d = S_OUT;
              end else begin
                // The last element is lifted out and walked down from the root.
                raddr   = last_idx[ADDR_W-1:0];
                state_d = S_DN_LAST;
              end
            end
          end
        end
      end

      S_UP: begin
        // Parent moves down into the hole while the new key is strictly larger.
        if (cur_q > rdata_q) begin
          we    = 1'b1;
          waddr = pos_q;
          wdata = rdata_q;
          pos_d = up_parent;
          if (up_parent == '0) begin
            state_d = S_WR;
          end else begin
            raddr = parent_idx(up_parent);
          end
        end else begin
          we      = 1'b1;
          state_d = S_OUT;
        end
      end

      S_WR: begin
        we      = 1'b1;
        state_d = S_OUT;
      end

      S_DN_LAST: begin
        cur_d = rdata_q;
        if (cnt_q == CNT_W'(1)) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = rdata_q;
          state_d = S_OUT;
        end else begin
          raddr   = ADDR_W'(1);
          state_d = S_DN_L;
        end
      end

      S_DN_L: begin
        if (rdata_q > cur_q) begin
          cand_key = rdata_q;
          cand_idx = left_w[ADDR_W-1:0];
        end
        if (right_w < cnt_ext) begin
          best_key_d = cand_key;
          best_idx_d = cand_idx;
          raddr      = right_w[ADDR_W-1:0];
          state_d    = S_DN_R;
        end else begin
          go_resolve = 1'b1;
        end
      end

      S_DN_R: begin
        cand_key = best_key_q;
        cand_idx = best_idx_q;
        if (rdata_q > best_key_q) begin
          cand_key = rdata_q;
          cand_idx = right_w[ADDR_W-1:0];
        end
        go_resolve = 1'b1;
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.removed_key = removed_q;
          out_d.top_key     = (cnt_q == '0) ? KEY_MIN : top_q;
          out_d.count       = cnt_q;
          out_d.is_empty    = (cnt_q == '0);
          out_d.status      = status_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Sift-down step: either the element settles here, or the larger child
    // moves up into the hole and the walk continues one level lower.
    if (go_resolve) begin
      we = 1'b1;
      if (cand_idx == pos_q) begin
        state_d = S_OUT;
      end else begin
        wdata = cand_key;
        pos_d = cand_idx;
        if (next_left_w >= cnt_ext) begin
          state_d = S_WR;
        end else begin
          raddr   = next_left_w[ADDR_W-1:0];
          state_d = S_DN_L;
        end
      end
    end
  end

  // The root is mirrored in a register so the maximum is known without a read.
  always_comb begin
    top_d = top_q;
    if (we && (waddr == '0)) begin
      top_d = wdata;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

FILE: sv/mhpq_checker.sv
`default_nettype none

module mhpq_checker
  import mhpq_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire mhpq_in_t  in_req_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire mhpq_out_t out_rsp_o
);

  // A request keeps the block busy for at least the cycle after it is taken.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_rsp_o)))
    else $error("stalled response changed or vanished");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.is_empty == (out_rsp_o.count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.is_empty) |-> (out_rsp_o.top_key == KEY_MIN))
    else $error("empty queue reports a maximum");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == ST_FULL)) |->
      (out_rsp_o.count == CNT_W'(CAPACITY)))
    else $error("insert dropped while not full");

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (.*);

`default_nettype wire
